@@ hdl/fept_pkg.sv @@
// ----------------------------------------------------------------------------
// fept_pkg
// Shared widths, reset values, register indexes and codes for the
// fall-end peak tracker.
// ----------------------------------------------------------------------------
package fept_pkg;

  localparam int SAMPLE_W          = 20;
  localparam int HISTORY_DEPTH_DEF = 20;
  localparam int CFG_IDX_W         = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_LOW     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_HIGH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_CEILING = 2'd2;

  // register reset values: 99^2, 102^2, 200^2
  localparam logic [SAMPLE_W-1:0] BAND_LOW_RST     = SAMPLE_W'(99 * 99);
  localparam logic [SAMPLE_W-1:0] BAND_HIGH_RST    = SAMPLE_W'(102 * 102);
  localparam logic [SAMPLE_W-1:0] PEAK_CEILING_RST = SAMPLE_W'(200 * 200);

  // sequence phases
  localparam logic [1:0] PH_ARM     = 2'd0;
  localparam logic [1:0] PH_CAPTURE = 2'd1;
  localparam logic [1:0] PH_REPORT  = 2'd2;
  localparam logic [1:0] PH_CLEAR   = 2'd3;

  // result event kinds
  localparam logic EV_PEAK_REPORT     = 1'b0;
  localparam logic EV_CAPTURE_DONE    = 1'b1;

endpackage

@@ hdl/fall_end_peak_tracker_unit.sv @@
// ----------------------------------------------------------------------------
// fall_end_peak_tracker_unit
// Arm / capture / report / clear sequencer over a ring of recent squared
// acceleration norms; reports the largest sample not above the ceiling once
// the whole ring sits inside the rest band.
// ----------------------------------------------------------------------------
//  channel | handshake        | payload
//  --------+------------------+---------------------------------------
//  in      | in_valid/in_stall| in_sample
//  out     | out_valid/out_stall | out_event_kind, out_peak_value
//  cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One sample per cycle is accepted while in_stall is low; each beat is held
// in the input register and resolved from there, and a beat that yields a
// result writes it into the result register. The rest test compares every
// ring entry in parallel, combinationally. Reset (rst_n low, synchronous)
// empties the ring and re-arms.
// in_stall rises only when a result-producing beat waits on a stalled output.
// ----------------------------------------------------------------------------
module fall_end_peak_tracker_unit
  import fept_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [SAMPLE_W-1:0]  in_sample,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_event_kind,
  output logic [SAMPLE_W-1:0]  out_peak_value,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SAMPLE_W-1:0]  cfg_data
);

  localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HISTORY_DEPTH - 1);

  // configuration
  logic [SAMPLE_W-1:0] band_low_r, band_high_r, peak_ceiling_r;

  // input register
  logic                s1_vld_r;
  logic [SAMPLE_W-1:0] s1_sample_r;

  // sequence state
  logic [1:0]               phase_r, phase_nxt;
  logic [IDX_W-1:0]         widx_r, widx_nxt;
  logic [SAMPLE_W-1:0]      peak_r, peak_nxt;
  logic [HISTORY_DEPTH-1:0] hvld_r, hvld_nxt;
  logic [SAMPLE_W-1:0]      hist_r [HISTORY_DEPTH];

  // result register
  logic                out_vld_r;
  logic                out_kind_r;
  logic [SAMPLE_W-1:0] out_peak_r;

  logic                has_result;
  logic                proc;
  logic                wr_hist;
  logic                at_rest;
  logic                res_kind;
  logic [SAMPLE_W-1:0] res_peak;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_low_r     <= BAND_LOW_RST;
      band_high_r    <= BAND_HIGH_RST;
      peak_ceiling_r <= PEAK_CEILING_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BAND_LOW:     band_low_r     <= cfg_data;
        CFG_BAND_HIGH:    band_high_r    <= cfg_data;
        CFG_PEAK_CEILING: peak_ceiling_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // a beat that emits a result needs the output register free
  assign has_result = (phase_r == PH_REPORT) || (phase_r == PH_CLEAR);
  assign proc       = s1_vld_r && (!has_result || !out_vld_r || !out_stall);
  assign in_stall   = s1_vld_r && !proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (!in_stall) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_sample_r <= in_sample;
    end
  end

  // rest test on the ring as it stands after this beat's write
  always_comb begin
    logic [SAMPLE_W-1:0] v;
    at_rest = 1'b1;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if (widx_r == IDX_W'(i)) begin
        v = s1_sample_r;
      end else if (hvld_r[i]) begin
        v = hist_r[i];
      end else begin
        v = '0;
      end
      if (v < band_low_r || v > band_high_r) begin
        at_rest = 1'b0;
      end
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    widx_nxt  = widx_r;
    peak_nxt  = peak_r;
    hvld_nxt  = hvld_r;
    wr_hist   = 1'b0;
    res_kind  = EV_PEAK_REPORT;
    res_peak  = peak_r;
    unique case (phase_r)
      PH_ARM: begin
        widx_nxt  = '0;
        phase_nxt = PH_CAPTURE;
      end
      PH_CAPTURE: begin
        wr_hist          = 1'b1;
        hvld_nxt[widx_r] = 1'b1;
        widx_nxt         = (widx_r == IDX_LAST) ? '0 : widx_r + IDX_W'(1);
        if (s1_sample_r > peak_r && s1_sample_r <= peak_ceiling_r) begin
          peak_nxt = s1_sample_r;
        end
        if (at_rest) begin
          phase_nxt = PH_REPORT;
        end
      end
      PH_REPORT: begin
        phase_nxt = PH_CLEAR;
      end
      PH_CLEAR: begin
        hvld_nxt  = '0;
        widx_nxt  = '0;
        peak_nxt  = '0;
        res_kind  = EV_CAPTURE_DONE;
        res_peak  = '0;
        phase_nxt = PH_ARM;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_ARM;
      widx_r  <= '0;
      peak_r  <= '0;
      hvld_r  <= '0;
    end else if (proc) begin
      phase_r <= phase_nxt;
      widx_r  <= widx_nxt;
      peak_r  <= peak_nxt;
      hvld_r  <= hvld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && wr_hist) begin
      hist_r[widx_r] <= s1_sample_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (proc && has_result) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && has_result) begin
      out_kind_r <= res_kind;
      out_peak_r <= res_peak;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_event_kind = out_kind_r;
  assign out_peak_value = out_peak_r;

endmodule

@@ hdl/fept_checker.sv @@
// ----------------------------------------------------------------------------
// fept_checker
// Port-level checks for the fall-end peak tracker, bound to the top level.
// ----------------------------------------------------------------------------
module fept_checker
  import fept_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 out_event_kind,
  input logic [SAMPLE_W-1:0]  out_peak_value
);

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_kind)
      && $stable(out_peak_value))
    else $error("result payload changed while stalled");

  // capture-complete beats always carry a cleared peak
  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == EV_CAPTURE_DONE) |-> out_peak_value == '0)
    else $error("capture-complete beat with nonzero peak");

  // input backpressure only comes from a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // reset drops any pending result
  a_rst_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind fall_end_peak_tracker_unit fept_checker u_fept_checker (.*);
